// ===== rtl/core/usf_pkg.sv =====
// Package for the URL span finder: shared types, character codes and sizes.
// Used by every module in rtl/core; has no dependencies of its own.
package usf_pkg;

    localparam int PosWidth     = 13;
    localparam int CharWidth    = 16;
    localparam int MaxLineDflt  = 4096;
    localparam int PosMaskValue = 8191;
    localparam int QueueDepth   = 4;
    localparam int QueuePtrW    = $clog2(QueueDepth);
    localparam int QueueCntW    = $clog2(QueueDepth + 1);

    // Character codes used by the prefix matcher.
    localparam logic [CharWidth-1:0] ChColon = 16'd58;
    localparam logic [CharWidth-1:0] ChLowH  = 16'd104;
    localparam logic [CharWidth-1:0] ChLowT  = 16'd116;
    localparam logic [CharWidth-1:0] ChLowP  = 16'd112;
    localparam logic [CharWidth-1:0] ChLowS  = 16'd115;
    localparam logic [CharWidth-1:0] ChLowF  = 16'd102;

    // Prefix lengths including the colon.
    localparam logic [2:0] PlenNone  = 3'd0;
    localparam logic [2:0] PlenFtp   = 3'd4;
    localparam logic [2:0] PlenHttp  = 3'd5;
    localparam logic [2:0] PlenHttps = 3'd6;

    // One classified character passed from the front end to the back end.
    typedef struct packed {
        logic [PosWidth-1:0] pos;
        logic [PosWidth-1:0] pos_inc;
        logic [PosWidth-1:0] span_start;
        logic                hit;
        logic                is_url;
        logic                last;
    } t_usf_item;

    function automatic logic is_url_char(input logic [CharWidth-1:0] c);
        logic r;
        r = (c == 16'd126) || (c >= 16'd97 && c <= 16'd122) ||
            (c == 16'd95)  || (c >= 16'd65 && c <= 16'd90)  ||
            (c == 16'd33)  || (c >= 16'd44 && c <= 16'd59)  ||
            (c == 16'd61)  || (c >= 16'd36 && c <= 16'd38)  ||
            (c == 16'd42)  || (c == 16'd63) || (c == 16'd35);
        return r;
    endfunction

endpackage

// ===== rtl/core/usf_front.sv =====
// Front end of the URL span finder: tracks position and character history,
// classifies each character and detects prefixes. Depends on usf_pkg.
module usf_front #(
    parameter int MAX_LINE = usf_pkg::MaxLineDflt
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [usf_pkg::CharWidth-1:0] i_text_char,
    input  logic                          i_line_end,
    input  logic [usf_pkg::PosWidth-1:0]  i_start_position,
    output usf_pkg::t_usf_item            o_item
);
    import usf_pkg::*;

    localparam int PosLimitInt = (MAX_LINE > PosMaskValue) ? PosMaskValue : MAX_LINE;
    localparam logic [PosWidth-1:0] PosLimit = PosLimitInt[PosWidth-1:0];

    logic [PosWidth-1:0]  r_pos, n_pos;
    logic [CharWidth-1:0] r_hist [5];
    logic [CharWidth-1:0] n_hist [5];

    logic [2:0]          plen;
    logic [PosWidth:0]   pos_p1;
    logic [PosWidth:0]   start_w;
    logic [PosWidth-1:0] pos_inc;

    always_comb begin
        plen = PlenNone;
        if (i_text_char == ChColon) begin
            if (r_hist[4] == ChLowH && r_hist[3] == ChLowT && r_hist[2] == ChLowT &&
                r_hist[1] == ChLowP && r_hist[0] == ChLowS) begin
                plen = PlenHttps;
            end else if (r_hist[3] == ChLowH && r_hist[2] == ChLowT &&
                         r_hist[1] == ChLowT && r_hist[0] == ChLowP) begin
                plen = PlenHttp;
            end else if (r_hist[2] == ChLowF && r_hist[1] == ChLowT &&
                         r_hist[0] == ChLowP) begin
                plen = PlenFtp;
            end
        end
    end

    assign pos_p1  = {1'b0, r_pos} + {{PosWidth{1'b0}}, 1'b1};
    assign start_w = pos_p1 - {{(PosWidth-2){1'b0}}, plen};
    assign pos_inc = (r_pos >= PosLimit) ? PosLimit : pos_p1[PosWidth-1:0];

    always_comb begin
        o_item.pos        = r_pos;
        o_item.pos_inc    = pos_inc;
        o_item.span_start = start_w[PosWidth-1:0];
        o_item.hit        = (plen != PlenNone) &&
                            (pos_p1 >= {{(PosWidth-2){1'b0}}, plen}) &&
                            (start_w >= {1'b0, i_start_position});
        o_item.is_url     = is_url_char(i_text_char);
        o_item.last       = i_line_end;
    end

    // History keeps shifting even inside a span; it only matters before the
    // first prefix of a line and is cleared at every line end.
    always_comb begin
        n_pos = r_pos;
        for (int k = 0; k < 5; k++) begin
            n_hist[k] = r_hist[k];
        end
        if (i_accept) begin
            if (i_line_end) begin
                n_pos = '0;
                for (int k = 0; k < 5; k++) begin
                    n_hist[k] = '0;
                end
            end else begin
                n_pos     = pos_inc;
                n_hist[0] = i_text_char;
                for (int k = 1; k < 5; k++) begin
                    n_hist[k] = r_hist[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int k = 0; k < 5; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            r_pos <= n_pos;
            for (int k = 0; k < 5; k++) begin
                r_hist[k] <= n_hist[k];
            end
        end
    end

endmodule

// ===== rtl/core/usf_queue.sv =====
// Short register queue between the front and back ends of the span finder.
// Holds classified characters; depends on usf_pkg.
module usf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  usf_pkg::t_usf_item i_data,
    input  logic               i_pop,
    output usf_pkg::t_usf_item o_data,
    output logic               o_empty,
    output logic               o_full
);
    import usf_pkg::*;

    t_usf_item              r_mem [QueueDepth];
    logic [QueuePtrW-1:0]   r_wp, n_wp;
    logic [QueuePtrW-1:0]   r_rp, n_rp;
    logic [QueueCntW-1:0]   r_cnt, n_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QueueDepth[QueueCntW-1:0]);

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/core/usf_back.sv =====
// Back end of the URL span finder: grows the span per line and registers
// one result per line for the output channel. Depends on usf_pkg.
module usf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pop,
    input  usf_pkg::t_usf_item           i_item,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_url_found,
    output logic [usf_pkg::PosWidth-1:0] o_begin_position,
    output logic [usf_pkg::PosWidth-1:0] o_end_position
);
    import usf_pkg::*;

    logic                r_in_span, n_in_span;
    logic                r_line_done, n_line_done;
    logic [PosWidth-1:0] r_span_start, n_span_start;
    logic                r_ov, n_ov;
    logic                r_found, n_found;
    logic [PosWidth-1:0] r_beg, n_beg;
    logic [PosWidth-1:0] r_end, n_end;

    logic                emit;
    logic                e_found;
    logic [PosWidth-1:0] e_beg;
    logic [PosWidth-1:0] e_end;

    always_comb begin
        n_in_span    = r_in_span;
        n_line_done  = r_line_done;
        n_span_start = r_span_start;
        emit         = 1'b0;
        e_found      = 1'b0;
        e_beg        = '0;
        e_end        = '0;
        if (i_pop) begin
            if (r_line_done) begin
                // The line's result has gone; the rest of the line is dropped.
                emit = 1'b0;
            end else if (r_in_span) begin
                if (!i_item.is_url) begin
                    emit        = 1'b1;
                    e_found     = 1'b1;
                    e_beg       = r_span_start;
                    e_end       = i_item.pos;
                    n_line_done = 1'b1;
                end else if (i_item.last) begin
                    emit    = 1'b1;
                    e_found = 1'b1;
                    e_beg   = r_span_start;
                    e_end   = i_item.pos_inc;
                end
            end else begin
                if (i_item.hit) begin
                    n_in_span    = 1'b1;
                    n_span_start = i_item.span_start;
                end
                if (i_item.last) begin
                    emit = 1'b1;
                    if (i_item.hit) begin
                        e_found = 1'b1;
                        e_beg   = i_item.span_start;
                        e_end   = i_item.pos_inc;
                    end
                end
            end
            if (i_item.last) begin
                n_in_span    = 1'b0;
                n_line_done  = 1'b0;
                n_span_start = '0;
            end
        end
    end

    always_comb begin
        n_ov    = r_ov && i_out_stall;
        n_found = r_found;
        n_beg   = r_beg;
        n_end   = r_end;
        if (emit) begin
            n_ov    = 1'b1;
            n_found = e_found;
            n_beg   = e_beg;
            n_end   = e_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_span    <= 1'b0;
            r_line_done  <= 1'b0;
            r_span_start <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_in_span    <= n_in_span;
            r_line_done  <= n_line_done;
            r_span_start <= n_span_start;
            r_ov         <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_beg   <= n_beg;
        r_end   <= n_end;
    end

    assign o_out_valid      = r_ov;
    assign o_url_found      = r_found;
    assign o_begin_position = r_beg;
    assign o_end_position   = r_end;

endmodule

// ===== rtl/core/url_span_finder.sv =====
// URL span finder, top level: front end, queue and back end of the scanner.
// Depends on usf_pkg, usf_front, usf_queue and usf_back.
// Throughput: one character per cycle; the front end takes a character into
// the four-entry queue while it is not full, and the back end retires one per
// cycle while the output register is free or being taken. The line's deciding
// character is registered in the queue and then in the output register.
// Reset (synchronous, active low) clears position, history, span state and
// the queue; no result is pending after reset.
module url_span_finder #(
    parameter int MAX_LINE = usf_pkg::MaxLineDflt
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [usf_pkg::CharWidth-1:0] i_text_char,
    input  logic                          i_line_end,
    input  logic [usf_pkg::PosWidth-1:0]  i_start_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_url_found,
    output logic [usf_pkg::PosWidth-1:0]  o_begin_position,
    output logic [usf_pkg::PosWidth-1:0]  o_end_position
);
    import usf_pkg::*;

    localparam int PosLimitInt = (MAX_LINE > PosMaskValue) ? PosMaskValue : MAX_LINE;
    localparam logic [PosWidth-1:0] PosLimit = PosLimitInt[PosWidth-1:0];

    t_usf_item front_item;
    t_usf_item head_item;
    logic      accept;
    logic      q_empty;
    logic      q_full;
    logic      pop;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;
    assign pop        = !q_empty && (!o_out_valid || !i_out_stall);

    usf_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_text_char     (i_text_char),
        .i_line_end      (i_line_end),
        .i_start_position(i_start_position),
        .o_item          (front_item)
    );

    usf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (front_item),
        .i_pop  (pop),
        .o_data (head_item),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    usf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pop           (pop),
        .i_item          (head_item),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_url_found     (o_url_found),
        .o_begin_position(o_begin_position),
        .o_end_position  (o_end_position)
    );

    // A found span always ends after its beginning.
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_url_found) |-> (o_end_position > o_begin_position))
        else $error("URL span ends at or before its beginning");

    // A line without a URL reports zero positions.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_url_found) |->
        (o_begin_position == '0 && o_end_position == '0))
        else $error("Non-zero positions reported for a line without a URL");

    // Reported positions never pass the saturation limit.
    a_end_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_end_position <= PosLimit))
        else $error("End position beyond the line limit");

endmodule
